@@ design/utf8cw_pkg.sv @@
// Package for the UTF-8 cluster display width block: types, constants and
// the range tables used by the decoder front end and the cluster back end.
// Depends on nothing.
`default_nettype none

package utf8cw_pkg;

  // Width of the running total; the result field shows its low 24 bits.
  localparam int TOTAL_BITS = 24;

  localparam logic [20:0] CP_REPL     = 21'h0FFFD;
  localparam logic [20:0] CP_ZWJ      = 21'h0200D;
  localparam logic [20:0] CP_VS16     = 21'h0FE0F;
  localparam logic [20:0] CP_KEYCAP   = 21'h020E3;
  localparam logic [20:0] CP_RI_FIRST = 21'h1F1E6;
  localparam logic [20:0] CP_RI_LAST  = 21'h1F1FF;

  localparam logic [7:0] BYTE_CONT_MIN = 8'h80;
  localparam logic [7:0] BYTE_LEAD2_MIN = 8'hC2;
  localparam logic [7:0] BYTE_LEAD4_MAX = 8'hF4;

  localparam int N_ZERO = 30;
  localparam int N_WIDE = 12;

  localparam logic [20:0] ZERO_LO [N_ZERO] = '{
    21'h0200B, 21'h02060, 21'h0FEFF, 21'h0FE00, 21'hE0100, 21'h1F3FB,
    21'h00300, 21'h00483, 21'h00591, 21'h005BF, 21'h005C1, 21'h00610,
    21'h0064B, 21'h00670, 21'h006D6, 21'h00711, 21'h00730, 21'h007A6,
    21'h007EB, 21'h00816, 21'h00859, 21'h008D3, 21'h0093A, 21'h00941,
    21'h00951, 21'h00962, 21'h01AB0, 21'h01DC0, 21'h020D0, 21'h0FE20};
  localparam logic [20:0] ZERO_HI [N_ZERO] = '{
    21'h0200D, 21'h02060, 21'h0FEFF, 21'h0FE0F, 21'hE01EF, 21'h1F3FF,
    21'h0036F, 21'h00489, 21'h005BD, 21'h005BF, 21'h005C2, 21'h0061A,
    21'h0065F, 21'h00670, 21'h006ED, 21'h00711, 21'h0074A, 21'h007B0,
    21'h007F3, 21'h0082D, 21'h0085B, 21'h00902, 21'h0093C, 21'h00948,
    21'h00957, 21'h00963, 21'h01AFF, 21'h01DFF, 21'h020FF, 21'h0FE2F};

  localparam logic [20:0] WIDE_LO [N_WIDE] = '{
    21'h01100, 21'h02329, 21'h02E80, 21'h03040, 21'h0AC00, 21'h0F900,
    21'h0FE10, 21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h1F000, 21'h20000};
  localparam logic [20:0] WIDE_HI [N_WIDE] = '{
    21'h0115F, 21'h0232A, 21'h0303E, 21'h0A4CF, 21'h0D7A3, 21'h0FAFF,
    21'h0FE19, 21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h1FAFF, 21'h3FFFD};

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  cluster_width;
    logic [23:0] total_width;
    logic        text_done;
    logic        run_last;
  } out_item_t;

  // Work one byte leaves for the back end: replacement characters for a
  // failed sequence, then the byte's own code point, then the flush of a
  // sequence cut short by the end of text, then the end-of-text close.
  typedef struct packed {
    logic [1:0]  n_pre;
    logic        has_cp;
    logic [20:0] cp;
    logic [1:0]  n_post;
    logic        is_end;
  } bundle_t;

  function automatic logic is_extender(input logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_ZERO; i++) begin
      if (cp >= ZERO_LO[i] && cp <= ZERO_HI[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic is_wide(input logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_WIDE; i++) begin
      if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

@@ design/utf8cw_front.sv @@
// UTF-8 decoder front end: validates each byte and turns it into a bundle
// of code point work for the queue, unless the byte is only buffered. Depends on utf8cw_pkg.
`default_nettype none

module utf8cw_front import utf8cw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          push_valid,
  input  wire logic     push_ready,
  output bundle_t       push_data
);

  logic [1:0] pend_cnt_r, pend_cnt_nxt;
  logic [2:0] exp_len_r, exp_len_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic [7:0] cont1_r, cont1_nxt;
  logic [7:0] cont2_r, cont2_nxt;

  logic       accept;
  logic       ok;
  logic       do_start;
  logic [7:0] b;
  bundle_t    bnd;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.text_byte;

  always_comb begin
    bnd          = '0;
    pend_cnt_nxt = pend_cnt_r;
    exp_len_nxt  = exp_len_r;
    lead_nxt     = lead_r;
    cont1_nxt    = cont1_r;
    cont2_nxt    = cont2_r;
    do_start     = 1'b0;
    ok           = 1'b0;

    if (pend_cnt_r == 2'd0) begin
      do_start = 1'b1;
    end else begin
      ok = (b[7:6] == 2'b10);
      if (pend_cnt_r == 2'd1) begin
        if (lead_r == 8'hE0 && b < 8'hA0) ok = 1'b0;
        if (lead_r == 8'hED && b >= 8'hA0) ok = 1'b0;
        if (lead_r == 8'hF0 && b < 8'h90) ok = 1'b0;
        if (lead_r == 8'hF4 && b > 8'h8F) ok = 1'b0;
      end
      if (!ok) begin
        bnd.n_pre    = pend_cnt_r;
        pend_cnt_nxt = 2'd0;
        exp_len_nxt  = 3'd0;
        do_start     = 1'b1;
      end else if ({1'b0, pend_cnt_r} + 3'd1 < exp_len_r) begin
        if (pend_cnt_r == 2'd1) begin
          cont1_nxt = b;
        end else begin
          cont2_nxt = b;
        end
        pend_cnt_nxt = pend_cnt_r + 2'd1;
      end else begin
        bnd.has_cp = 1'b1;
        case (exp_len_r)
          3'd2:    bnd.cp = {10'd0, lead_r[4:0], b[5:0]};
          3'd3:    bnd.cp = {5'd0, lead_r[3:0], cont1_r[5:0], b[5:0]};
          default: bnd.cp = {lead_r[2:0], cont1_r[5:0], cont2_r[5:0], b[5:0]};
        endcase
        pend_cnt_nxt = 2'd0;
        exp_len_nxt  = 3'd0;
      end
    end

    if (do_start) begin
      if (b < BYTE_CONT_MIN) begin
        bnd.has_cp = 1'b1;
        bnd.cp     = {13'd0, b};
      end else if (b >= BYTE_LEAD2_MIN && b <= BYTE_LEAD4_MAX) begin
        lead_nxt     = b;
        pend_cnt_nxt = 2'd1;
        if (b <= 8'hDF) begin
          exp_len_nxt = 3'd2;
        end else if (b <= 8'hEF) begin
          exp_len_nxt = 3'd3;
        end else begin
          exp_len_nxt = 3'd4;
        end
      end else begin
        bnd.has_cp = 1'b1;
        bnd.cp     = CP_REPL;
      end
    end

    if (in_data.text_end) begin
      bnd.n_post   = pend_cnt_nxt;
      bnd.is_end   = 1'b1;
      pend_cnt_nxt = 2'd0;
      exp_len_nxt  = 3'd0;
    end
  end

  assign push_data  = bnd;
  // A byte that is only buffered leaves no work behind.
  assign push_valid = accept && (bnd.n_pre != 2'd0 || bnd.has_cp || bnd.is_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
      exp_len_r  <= 3'd0;
    end else if (accept) begin
      pend_cnt_r <= pend_cnt_nxt;
      exp_len_r  <= exp_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lead_r  <= lead_nxt;
      cont1_r <= cont1_nxt;
      cont2_r <= cont2_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/utf8cw_queue.sv @@
// Two-entry queue of decoded bundles between front and back end.
// Depends on utf8cw_pkg.
`default_nettype none

module utf8cw_queue import utf8cw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire bundle_t push_data,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output bundle_t      pop_data
);

  bundle_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

@@ design/utf8cw_back.sv @@
// Cluster back end: walks each bundle one code point per cycle unless the result
// path stalls, keeps the cluster state and running total, and drives the result
// register. Depends on utf8cw_pkg.
`default_nettype none

module utf8cw_back import utf8cw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    pop_valid,
  output logic         pop_ready,
  input  wire bundle_t pop_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_item_t    out_data
);

  typedef enum logic [1:0] {TOK_REPL, TOK_CP, TOK_END} tok_t;

  logic [2:0]            step_r;
  logic                  awaiting_r, joiner_r, base_ri_r;
  logic [1:0]            cur_w_r;
  logic [TOTAL_BITS-1:0] sum_r;
  logic                  hold_v_r, hold_fin_r;
  out_item_t             hold_r;
  logic                  out_v_r;
  out_item_t             out_r;

  logic [2:0]            step_nxt;
  logic                  awaiting_nxt, joiner_nxt, base_ri_nxt;
  logic [1:0]            cur_w_nxt;
  logic [TOTAL_BITS-1:0] sum_nxt;

  tok_t                  kind;
  logic [3:0]            total;
  logic [3:0]            pre_cp;
  logic                  is_last;
  logic [20:0]           cp;
  logic                  ext, ri, pair, emit_c, new_r, step_go, back_go, out_free, move;
  logic [TOTAL_BITS:0]   sum_add;
  logic [TOTAL_BITS-1:0] sat;
  logic [TOTAL_BITS+23:0] sum_wide;
  out_item_t             res;

  assign pre_cp  = {2'd0, pop_data.n_pre} + {3'd0, pop_data.has_cp};
  assign total   = pre_cp + {2'd0, pop_data.n_post} + {3'd0, pop_data.is_end};
  assign is_last = ({1'b0, step_r} + 4'd1 == total);

  always_comb begin
    if ({1'b0, step_r} < {2'd0, pop_data.n_pre}) begin
      kind = TOK_REPL;
    end else if (pop_data.has_cp && {1'b0, step_r} == {2'd0, pop_data.n_pre}) begin
      kind = TOK_CP;
    end else if ({1'b0, step_r} < pre_cp + {2'd0, pop_data.n_post}) begin
      kind = TOK_REPL;
    end else begin
      kind = TOK_END;
    end
  end

  assign cp      = (kind == TOK_CP) ? pop_data.cp : CP_REPL;
  assign ext     = is_extender(cp);
  assign ri      = (cp >= CP_RI_FIRST && cp <= CP_RI_LAST);
  assign pair    = !awaiting_r && base_ri_r && ri;
  assign emit_c  = !awaiting_r && !joiner_r && !ext && !pair;

  assign sum_add  = {1'b0, sum_r} + {{(TOTAL_BITS-1){1'b0}}, cur_w_r};
  assign sat      = sum_add[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum_add[TOTAL_BITS-1:0];
  assign sum_wide = {24'd0, sat};

  assign new_r    = pop_valid && (kind == TOK_END || emit_c);
  assign out_free = !out_v_r || out_ready;
  assign back_go  = !(hold_v_r && (hold_fin_r || new_r) && !out_free);
  assign step_go  = pop_valid && back_go;
  assign move     = hold_v_r && (hold_fin_r || new_r) && out_free;
  assign pop_ready = step_go && is_last;
  assign step_nxt = is_last ? 3'd0 : step_r + 3'd1;

  always_comb begin
    res.cluster_width = cur_w_r;
    res.total_width   = sum_wide[23:0];
    res.text_done     = (kind == TOK_END);
    res.run_last      = is_last;

    awaiting_nxt = awaiting_r;
    joiner_nxt   = joiner_r;
    base_ri_nxt  = base_ri_r;
    cur_w_nxt    = cur_w_r;
    sum_nxt      = sum_r;

    if (kind == TOK_END) begin
      awaiting_nxt = 1'b1;
      joiner_nxt   = 1'b0;
      base_ri_nxt  = 1'b0;
      cur_w_nxt    = 2'd0;
      sum_nxt      = '0;
    end else begin
      if (emit_c) begin
        sum_nxt      = sat;
        awaiting_nxt = 1'b1;
        joiner_nxt   = 1'b0;
        base_ri_nxt  = 1'b0;
        cur_w_nxt    = 2'd0;
      end
      if (cp == CP_VS16 || cp == CP_KEYCAP) cur_w_nxt = 2'd2;
      if (cp == CP_ZWJ) begin
        joiner_nxt = 1'b1;
      end else if (!ext) begin
        if (is_wide(cp)) begin
          cur_w_nxt = 2'd2;
        end else if (cur_w_nxt == 2'd0) begin
          cur_w_nxt = 2'd1;
        end
        if (awaiting_nxt) base_ri_nxt = ri;
        awaiting_nxt = 1'b0;
        joiner_nxt   = 1'b0;
        if (pair) base_ri_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= 3'd0;
      awaiting_r <= 1'b1;
      joiner_r   <= 1'b0;
      base_ri_r  <= 1'b0;
      cur_w_r    <= 2'd0;
      sum_r      <= '0;
      hold_v_r   <= 1'b0;
      hold_fin_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (step_go) begin
        step_r     <= step_nxt;
        awaiting_r <= awaiting_nxt;
        joiner_r   <= joiner_nxt;
        base_ri_r  <= base_ri_nxt;
        cur_w_r    <= cur_w_nxt;
        sum_r      <= sum_nxt;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (step_go && new_r) begin
        hold_v_r   <= 1'b1;
        hold_fin_r <= is_last;
      end else if (move) begin
        hold_v_r   <= 1'b0;
        hold_fin_r <= 1'b0;
      end else if (step_go && is_last && hold_v_r) begin
        hold_fin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) out_r <= hold_r;
    if (step_go && new_r) begin
      hold_r <= res;
    end else if (step_go && is_last && hold_v_r && !move) begin
      hold_r.run_last <= 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_fin_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hold_fin_r |-> hold_v_r)
    else $error("final result flag set without a held result");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.cluster_width != 2'd3)
    else $error("cluster width out of range");

  a_end_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && kind == TOK_END) |=> (sum_r == '0 && awaiting_r))
    else $error("end of text did not clear the running total");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ready |-> pop_valid)
    else $error("bundle retired from an empty queue");

endmodule

`default_nettype wire

@@ design/utf8_cluster_display_width.sv @@
// Top level of the UTF-8 cluster display width block: front decoder, bundle
// queue and cluster back end. Depends on utf8cw_pkg and the utf8cw_ modules.
//
//   Port group  Direction  Handshake          Payload
//   in_         input      in_valid/in_ready  in_item_t  (text_byte, text_end)
//   out_        output     out_valid/out_ready out_item_t (width, total, done, last)
//
// The front end takes one request per cycle whenever the queue has room. The
// back end handles one code point per cycle while its results can move on, so a
// byte that brings more than one code point (replacement characters of a failed
// sequence, its own code point, the end-of-text close) holds it until each is
// handled; unstalled plain text runs at one byte and at most one result per cycle.
// Reset is synchronous and active low; it empties the queue and returns the
// decoder and cluster state to the start of a text. There is no clearing pass.
// A stalled result register parks one result; the back end keeps one more in
// a holding register until it knows whether it is the last result of its
// request, and the queue absorbs two bundles before in_ready falls.
`default_nettype none

module utf8_cluster_display_width import utf8cw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  logic    push_valid, push_ready;
  bundle_t push_data;
  logic    pop_valid, pop_ready;
  bundle_t pop_data;

  // Decoder: validates the byte stream and forms at most one bundle per request.
  utf8cw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Short queue so the decoder and the cluster logic stall independently.
  utf8cw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Cluster grouping, widths and the saturating running total.
  utf8cw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ verif/tb_utf8_cluster_display_width.sv @@
// Self-checking testbench for utf8_cluster_display_width: directed byte table,
// then random UTF-8 text checked against a cluster-width predictor held here.
// Depends on utf8cw_pkg and the design top level.
`timescale 1ns / 100ps

module tb_utf8_cluster_display_width;
  import utf8cw_pkg::*;

  // Clock, reset and ports of the block.
  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  utf8_cluster_display_width dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Predictor state: a private copy of the decoder and cluster registers.
  int unsigned         seq_count;
  logic [23:0]         seq_bytes;
  int unsigned         seq_len;
  logic                clu_open;
  logic                want_base;
  logic                joined;
  logic                base_ri;
  logic [1:0]          clu_width;
  logic [TOTAL_BITS:0] col_sum;

  // Results expected but not yet seen, oldest first.
  out_item_t widths_due[$];
  // Results produced by the request now being predicted.
  out_item_t step_widths[$];

  int errors;
  int requests_sent;
  int results_seen;
  int texts_ended;
  longint cycle_count;
  bit     long_hold;
  localparam longint CYCLE_LIMIT = 400000;

  // Zero-width and wide ranges, written out here as plain comparisons.
  function automatic bit zero_cp(input logic [20:0] c);
    return (c >= 21'h200B && c <= 21'h200D) || c == 21'h2060 || c == 21'hFEFF ||
      (c >= 21'hFE00 && c <= 21'hFE0F) || (c >= 21'hE0100 && c <= 21'hE01EF) ||
      (c >= 21'h1F3FB && c <= 21'h1F3FF) || (c >= 21'h0300 && c <= 21'h036F) ||
      (c >= 21'h0483 && c <= 21'h0489) || (c >= 21'h0591 && c <= 21'h05BD) ||
      c == 21'h05BF || (c >= 21'h05C1 && c <= 21'h05C2) ||
      (c >= 21'h0610 && c <= 21'h061A) || (c >= 21'h064B && c <= 21'h065F) ||
      c == 21'h0670 || (c >= 21'h06D6 && c <= 21'h06ED) || c == 21'h0711 ||
      (c >= 21'h0730 && c <= 21'h074A) || (c >= 21'h07A6 && c <= 21'h07B0) ||
      (c >= 21'h07EB && c <= 21'h07F3) || (c >= 21'h0816 && c <= 21'h082D) ||
      (c >= 21'h0859 && c <= 21'h085B) || (c >= 21'h08D3 && c <= 21'h0902) ||
      (c >= 21'h093A && c <= 21'h093C) || (c >= 21'h0941 && c <= 21'h0948) ||
      (c >= 21'h0951 && c <= 21'h0957) || (c >= 21'h0962 && c <= 21'h0963) ||
      (c >= 21'h1AB0 && c <= 21'h1AFF) || (c >= 21'h1DC0 && c <= 21'h1DFF) ||
      (c >= 21'h20D0 && c <= 21'h20FF) || (c >= 21'hFE20 && c <= 21'hFE2F);
  endfunction

  function automatic bit wide_cp(input logic [20:0] c);
    return (c >= 21'h1100 && c <= 21'h115F) || (c >= 21'h2329 && c <= 21'h232A) ||
      (c >= 21'h2E80 && c <= 21'h303E) || (c >= 21'h3040 && c <= 21'hA4CF) ||
      (c >= 21'hAC00 && c <= 21'hD7A3) || (c >= 21'hF900 && c <= 21'hFAFF) ||
      (c >= 21'hFE10 && c <= 21'hFE19) || (c >= 21'hFE30 && c <= 21'hFE6F) ||
      (c >= 21'hFF00 && c <= 21'hFF60) || (c >= 21'hFFE0 && c <= 21'hFFE6) ||
      (c >= 21'h1F000 && c <= 21'h1FAFF) || (c >= 21'h20000 && c <= 21'h3FFFD);
  endfunction

  // Closes a cluster: the total saturates at the top of TOTAL_BITS.
  function automatic void close_cluster(input logic [1:0] w, input bit last_of_text);
    out_item_t r;
    logic [TOTAL_BITS:0] cap;
    cap = {1'b0, {TOTAL_BITS{1'b1}}};
    if (step_widths.size() >= 5) return;
    if (col_sum > cap - w) col_sum = cap;
    else col_sum = col_sum + w;
    r.cluster_width = w;
    r.total_width   = col_sum[23:0];
    r.text_done     = last_of_text;
    r.run_last      = 1'b0;
    step_widths = {step_widths, r};
  endfunction

  function automatic void reset_cluster();
    clu_open  = 1'b0;
    want_base = 1'b1;
    joined    = 1'b0;
    base_ri   = 1'b0;
    clu_width = 2'd0;
  endfunction

  // One code point into the cluster grouping.
  function automatic void add_code_point(input logic [20:0] c);
    bit ext, ri, pair, ctrl;
    logic [1:0] w;
    ext  = zero_cp(c);
    ri   = c >= CP_RI_FIRST && c <= CP_RI_LAST;
    pair = !want_base && base_ri && ri;
    if (!want_base && !joined && !ext && !pair) begin
      close_cluster(clu_width, 1'b0);
      reset_cluster();
    end
    clu_open = 1'b1;
    if (c == CP_VS16 || c == CP_KEYCAP) clu_width = 2'd2;
    if (c == CP_ZWJ) begin
      joined = 1'b1;
      return;
    end
    if (!ext) begin
      ctrl = c < 21'h20 || (c >= 21'h7F && c <= 21'h9F);
      w = ctrl ? 2'd1 : (wide_cp(c) ? 2'd2 : 2'd1);
      if (w > clu_width) clu_width = w;
      if (want_base) base_ri = ri;
      want_base = 1'b0;
      joined    = 1'b0;
      if (pair) base_ri = 1'b0;
    end
  endfunction

  // A failed or cut-short sequence gives one replacement per buffered byte.
  function automatic void flush_sequence();
    for (int i = 0; i < seq_count; i++) add_code_point(CP_REPL);
    seq_count = 0;
    seq_bytes = '0;
    seq_len   = 0;
  endfunction

  function automatic void begin_sequence(input logic [7:0] b);
    int unsigned n;
    n = 0;
    if (b < BYTE_CONT_MIN) begin
      add_code_point({13'd0, b});
      return;
    end
    if (b >= BYTE_LEAD2_MIN && b <= 8'hDF) n = 2;
    else if (b >= 8'hE0 && b <= 8'hEF) n = 3;
    else if (b >= 8'hF0 && b <= BYTE_LEAD4_MAX) n = 4;
    if (n == 0) begin
      add_code_point(CP_REPL);
      return;
    end
    seq_bytes = {16'd0, b};
    seq_count = 1;
    seq_len   = n;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [7:0]  lead;
    logic [20:0] c;
    bit ok;
    if (seq_count == 0) begin
      begin_sequence(b);
      return;
    end
    lead = seq_bytes[7:0];
    ok = b[7:6] == 2'b10;
    if (ok && seq_count == 1) begin
      if (lead == 8'hE0 && b < 8'hA0) ok = 0;
      if (lead == 8'hED && b >= 8'hA0) ok = 0;
      if (lead == 8'hF0 && b < 8'h90) ok = 0;
      if (lead == BYTE_LEAD4_MAX && b > 8'h8F) ok = 0;
    end
    if (!ok) begin
      flush_sequence();
      begin_sequence(b);
      return;
    end
    if (seq_count + 1 < seq_len && seq_count < 3) begin
      seq_bytes[8*seq_count +: 8] = b;
      seq_count++;
      return;
    end
    if (seq_len == 2) c = {10'd0, lead[4:0], b[5:0]};
    else if (seq_len == 3) c = {5'd0, lead[3:0], seq_bytes[13:8], b[5:0]};
    else c = {lead[2:0], seq_bytes[13:8], seq_bytes[21:16], b[5:0]};
    seq_count = 0;
    seq_bytes = '0;
    seq_len   = 0;
    add_code_point(c);
  endfunction

  // Works out every result one accepted request causes and queues them.
  function automatic void predict_widths(input in_item_t req);
    out_item_t r;
    step_widths.delete();
    decode_byte(req.text_byte);
    if (req.text_end) begin
      flush_sequence();
      close_cluster(clu_width, 1'b1);
      reset_cluster();
      col_sum = '0;
    end
    if (step_widths.size() > 0) step_widths[step_widths.size()-1].run_last = 1'b1;
    foreach (step_widths[i]) begin
      r = step_widths[i];
      widths_due = {widths_due, r};
    end
  endfunction

  // Directed table. A width of 3 in the check column means that the row is
  // left to the predictor; otherwise the listed results are compared too.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
    logic [1:0] first_width;
    logic       first_done;
  } dir_row_t;

  localparam int N_DIR = 25;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{8'h00, 1'b1, 2'd1, 1'b1},   // control alone, ends a text at once
    '{8'hFF, 1'b1, 2'd1, 1'b1},   // invalid lead, replacement of width 1
    '{8'h80, 1'b1, 2'd1, 1'b1},   // stray continuation
    '{8'hC1, 1'b0, 2'd3, 1'b0},   // overlong lead
    '{8'hE3, 1'b0, 2'd3, 1'b0},   // hiragana: E3 81 82
    '{8'h81, 1'b0, 2'd3, 1'b0},
    '{8'h82, 1'b0, 2'd3, 1'b0},
    '{8'hEF, 1'b0, 2'd3, 1'b0},   // emoji selector EF B8 8F
    '{8'hB8, 1'b0, 2'd3, 1'b0},
    '{8'h8F, 1'b0, 2'd3, 1'b0},
    '{8'hED, 1'b0, 2'd3, 1'b0},   // surrogate ED A0: two replacements
    '{8'hA0, 1'b0, 2'd3, 1'b0},
    '{8'hE0, 1'b0, 2'd3, 1'b0},   // overlong E0 80
    '{8'h80, 1'b0, 2'd3, 1'b0},
    '{8'hF0, 1'b0, 2'd3, 1'b0},   // regional indicator F0 9F 87 A6 twice
    '{8'h9F, 1'b0, 2'd3, 1'b0},
    '{8'h87, 1'b0, 2'd3, 1'b0},
    '{8'hA6, 1'b0, 2'd3, 1'b0},
    '{8'hF0, 1'b0, 2'd3, 1'b0},
    '{8'h9F, 1'b0, 2'd3, 1'b0},
    '{8'h87, 1'b0, 2'd3, 1'b0},
    '{8'hA6, 1'b0, 2'd3, 1'b0},
    '{8'hF4, 1'b0, 2'd3, 1'b0},   // above U+10FFFF: F4 90
    '{8'h90, 1'b0, 2'd3, 1'b0},
    '{8'hF4, 1'b1, 2'd3, 1'b0}    // sequence cut short by the end of text
  };

  // Pieces from which random text is built: well-formed code points of every
  // kind the grouping cares about, with now and then a broken one.
  function automatic void random_piece(ref logic [7:0] piece[$]);
    logic [20:0] c;
    int k;
    k = $urandom_range(0, 15);
    piece.delete();
    case (k)
      0: c = 21'($urandom_range(0, 21'h7F));
      1: c = CP_ZWJ;
      2: c = CP_VS16;
      3: c = CP_KEYCAP;
      4: c = 21'($urandom_range(21'h1F1E6, 21'h1F1FF));
      5: c = 21'($urandom_range(21'h0300, 21'h036F));
      6: c = 21'($urandom_range(21'h3040, 21'hA4CF));
      7: c = 21'($urandom_range(21'h1F300, 21'h1F64F));
      8: c = 21'($urandom_range(21'h1F3FB, 21'h1F3FF));
      9: c = 21'($urandom_range(21'h80, 21'h7FF));
      10: c = 21'($urandom_range(21'h10000, 21'h10FFFF));
      11: c = 21'($urandom_range(21'hE000, 21'hFFFF));
      12: c = 21'($urandom_range(21'h20, 21'h7E));
      default: c = 21'h1FFFFF;
    endcase
    if (c == 21'h1FFFFF) begin
      // Noise: any byte at all.
      piece = {piece, 8'($urandom_range(0, 255))};
    end else if (c < 21'h80) begin
      piece = {piece, c[7:0]};
    end else if (c < 21'h800) begin
      piece = {piece, {3'b110, c[10:6]}};
      piece = {piece, {2'b10, c[5:0]}};
    end else if (c < 21'h10000) begin
      if (c >= 21'hD800 && c <= 21'hDFFF) c = 21'hFFFD;
      piece = {piece, {4'b1110, c[15:12]}};
      piece = {piece, {2'b10, c[11:6]}};
      piece = {piece, {2'b10, c[5:0]}};
    end else begin
      piece = {piece, {5'b11110, c[20:18]}};
      piece = {piece, {2'b10, c[17:12]}};
      piece = {piece, {2'b10, c[11:6]}};
      piece = {piece, {2'b10, c[5:0]}};
    end
    // A broken sequence: drop its tail now and then.
    if (piece.size() > 1 && $urandom_range(0, 9) == 0) void'(piece.pop_back());
  endfunction

  // Sends one request: a random gap first, then valid held until accepted.
  // Returns at the accepting edge; valid drops at the next falling edge only
  // when a gap follows, so requests can run back to back.
  task automatic send_request(input logic [7:0] b, input logic e);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 2) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{text_byte: b, text_end: e};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_widths('{text_byte: b, text_end: e});
    requests_sent++;
    if (e) texts_ended++;
  endtask

  // Receiver: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (widths_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        want = widths_due.pop_front();
        if (out_data.cluster_width !== want.cluster_width) begin
          errors++;
          $display("%0t: cluster_width expected %0d actual %0d", $time,
                   want.cluster_width, out_data.cluster_width);
        end
        if (out_data.total_width !== want.total_width) begin
          errors++;
          $display("%0t: total_width expected %0d actual %0d", $time,
                   want.total_width, out_data.total_width);
        end
        if (out_data.text_done !== want.text_done) begin
          errors++;
          $display("%0t: text_done expected %0b actual %0b", $time,
                   want.text_done, out_data.text_done);
        end
        if (out_data.run_last !== want.run_last) begin
          errors++;
          $display("%0t: run_last expected %0b actual %0b", $time,
                   want.run_last, out_data.run_last);
        end
      end
    end
  end

  // Ready drawn per result after a random wait, often none; a long hold-off
  // is forced once so that the queue fills and in_ready falls.
  initial begin
    int wait_cycles;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (60) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) wait_cycles = 0;
        if (wait_cycles > 0) begin
          out_ready <= 1'b0;
          repeat (wait_cycles) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus: reset, the directed table, then random text.
  initial begin
    logic [7:0] piece[$];
    dir_row_t   row;
    errors = 0;
    requests_sent = 0;
    results_seen = 0;
    texts_ended = 0;
    cycle_count = 0;
    long_hold = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    seq_count = 0;
    seq_bytes = '0;
    seq_len   = 0;
    reset_cluster();
    col_sum = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      send_request(row.text_byte, row.text_end);
      // Rows with a known single result: the typed-in value must agree with
      // what was predicted, so a predictor slip shows up here as well.
      if (row.first_width != 2'd3) begin
        if (step_widths.size() != 1 ||
            step_widths[0].cluster_width !== row.first_width ||
            step_widths[0].text_done !== row.first_done) begin
          errors++;
          $display("%0t: row %0d expected width %0d done %0b, predicted other", $time,
                   i, row.first_width, row.first_done);
        end
      end
    end

    // Random text; the receiver holds off once early on, and the sender
    // pauses once until the block has drained.
    for (int n = 0; requests_sent < 249; n++) begin
      if (n == 20) long_hold = 1'b1;
      if (n == 60) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (widths_due.size() != 0) @(negedge clk);
      end
      random_piece(piece);
      foreach (piece[j])
        send_request(piece[j], (j == piece.size() - 1) && ($urandom_range(0, 19) == 0));
    end
    send_request(8'h41, 1'b1);
    @(negedge clk);
    in_valid <= 1'b0;

    while (widths_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d byte requests over %0d texts; %0d results checked.",
             requests_sent, texts_ended, results_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
